// ===== sv/sdes_pkg.sv =====
// Shared types, constants and bit permutations for the S-DES byte cipher.
package sdes_pkg;

    localparam int KEY_W  = 10;
    localparam int BLK_W  = 8;
    localparam int HALF_W = 4;
    localparam int SUB_W  = 8;
    localparam int IDX_W  = 1;

    typedef logic [KEY_W-1:0]  key_t;
    typedef logic [BLK_W-1:0]  blk_t;
    typedef logic [HALF_W-1:0] nib_t;
    typedef logic [SUB_W-1:0]  sub_t;
    typedef logic [1:0]        sval_t;
    typedef logic [IDX_W-1:0]  idx_t;

    // Configuration register indexes
    localparam idx_t REG_KEY = 1'b0;
    localparam idx_t REG_ALT = 1'b1;

    // Operation codes
    localparam logic OP_ENC = 1'b0;
    localparam logic OP_DEC = 1'b1;

    // S-boxes, addressed by {row, col} with row = {n[3], n[0]}, col = n[2:1]
    localparam sval_t S0_TAB [16] = '{
        2'd1, 2'd0, 2'd3, 2'd2,
        2'd3, 2'd2, 2'd1, 2'd0,
        2'd0, 2'd2, 2'd1, 2'd3,
        2'd3, 2'd1, 2'd3, 2'd2
    };
    localparam sval_t S1_TAB [16] = '{
        2'd0, 2'd1, 2'd2, 2'd3,
        2'd2, 2'd0, 2'd1, 2'd3,
        2'd3, 2'd0, 2'd1, 2'd0,
        2'd2, 2'd1, 2'd0, 2'd3
    };
    localparam sval_t S1_ALT_TAB [16] = '{
        2'd2, 2'd1, 2'd0, 2'd3,
        2'd2, 2'd0, 2'd1, 2'd3,
        2'd3, 2'd0, 2'd1, 2'd0,
        2'd0, 2'd1, 2'd2, 2'd3
    };

    // Table position 1 is the MSB, so position p of a w-bit word is bit w-p.
    function automatic key_t p10(input key_t k);
        return {k[7], k[5], k[8], k[3], k[6], k[0], k[9], k[1], k[2], k[4]};
    endfunction

    function automatic sub_t p8(input key_t k);
        return {k[4], k[7], k[3], k[6], k[2], k[5], k[0], k[1]};
    endfunction

    function automatic nib_t p4(input nib_t v);
        return {v[2], v[0], v[1], v[3]};
    endfunction

    function automatic blk_t ip(input blk_t b);
        return {b[6], b[2], b[5], b[7], b[4], b[0], b[3], b[1]};
    endfunction

    function automatic blk_t ip_inv(input blk_t b);
        return {b[4], b[7], b[5], b[3], b[1], b[6], b[0], b[2]};
    endfunction

    function automatic sub_t ep(input nib_t r);
        return {r[0], r[3], r[2], r[1], r[2], r[1], r[0], r[3]};
    endfunction

    function automatic logic [3:0] sbox_addr(input nib_t n);
        return {n[3], n[0], n[2], n[1]};
    endfunction

endpackage

// ===== sv/sdes_key_sched.sv =====
// Key schedule: derives subkeys K1 and K2 from the 10-bit key.
module sdes_key_sched
(
    input  sdes_pkg::key_t key,
    output sdes_pkg::sub_t k1,
    output sdes_pkg::sub_t k2
);

    sdes_pkg::key_t perm;
    logic [4:0]     hl1;
    logic [4:0]     hr1;
    logic [4:0]     hl2;
    logic [4:0]     hr2;

    always_comb
    begin
        perm = sdes_pkg::p10(key);
        // rotate each half left by one, then by two more
        hl1  = {perm[8:5], perm[9]};
        hr1  = {perm[3:0], perm[4]};
        hl2  = {hl1[2:0], hl1[4:3]};
        hr2  = {hr1[2:0], hr1[4:3]};
        k1   = sdes_pkg::p8({hl1, hr1});
        k2   = sdes_pkg::p8({hl2, hr2});
    end

endmodule

// ===== sv/sdes_round.sv =====
// One fk round: expand, mix subkey, S-box lookup, P4, fold into left half.
module sdes_round
(
    input  sdes_pkg::blk_t blk_in,
    input  sdes_pkg::sub_t subkey,
    input  logic           alt_s1,
    output sdes_pkg::blk_t blk_out
);

    sdes_pkg::sub_t  mix;
    sdes_pkg::sval_t s0;
    sdes_pkg::sval_t s1;
    sdes_pkg::nib_t  f;

    always_comb
    begin
        mix = sdes_pkg::ep(blk_in[3:0]) ^ subkey;
        s0  = sdes_pkg::S0_TAB[sdes_pkg::sbox_addr(mix[7:4])];
        if (alt_s1)
            s1 = sdes_pkg::S1_ALT_TAB[sdes_pkg::sbox_addr(mix[3:0])];
        else
            s1 = sdes_pkg::S1_TAB[sdes_pkg::sbox_addr(mix[3:0])];
        f       = sdes_pkg::p4({s0, s1});
        blk_out = {blk_in[7:4] ^ f, blk_in[3:0]};
    end

endmodule

// ===== sv/sdes_byte_cipher.sv =====
// Top level: S-DES byte cipher with input register, round logic and result register.
//
// The block encrypts (opcode 0) or decrypts (opcode 1) one byte per beat
// with Simplified DES under the 10-bit key in register 0; register 1 set to
// one selects the modified S1 table. busy is always low, so a beat is taken
// in every cycle that start is high. Each beat's result shows on data_out
// with done high for exactly one cycle, after the beat has passed through
// the input register, the whole key schedule and both rounds in one pass
// of combinational logic, and then the result register. The receiver
// cannot stall the block. Write the configuration only while no beat is
// in flight.
module sdes_byte_cipher
(
    input  logic                    clk,
    input  logic                    rst_n,
    input  logic                    start,
    output logic                    busy,
    input  logic                    opcode,
    input  sdes_pkg::blk_t          data_in,
    output logic                    done,
    output sdes_pkg::blk_t          data_out,
    input  logic                    wr_en,
    input  sdes_pkg::idx_t          wr_index,
    input  logic [sdes_pkg::KEY_W-1:0] wr_data
);

    sdes_pkg::key_t key_reg;
    logic           alt_reg;

    logic           vld_reg;
    logic           op_reg;
    sdes_pkg::blk_t din_reg;
    logic           done_reg;
    sdes_pkg::blk_t dout_reg;
    sdes_pkg::blk_t dout_next;

    sdes_pkg::sub_t k1;
    sdes_pkg::sub_t k2;
    sdes_pkg::sub_t first_key;
    sdes_pkg::sub_t second_key;
    sdes_pkg::blk_t r1_in;
    sdes_pkg::blk_t r1_out;
    sdes_pkg::blk_t r2_in;
    sdes_pkg::blk_t r2_out;

    assign busy     = 1'b0;
    assign done     = done_reg;
    assign data_out = dout_reg;

    // configuration registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            key_reg <= '0;
            alt_reg <= 1'b0;
        end
        else if (wr_en)
        begin
            case (wr_index)
                sdes_pkg::REG_KEY: key_reg <= wr_data;
                sdes_pkg::REG_ALT: alt_reg <= wr_data[0];
                default:           ;
            endcase
        end
    end

    // input register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            vld_reg <= 1'b0;
        else
            vld_reg <= start && !busy;
    end

    always_ff @(posedge clk)
    begin
        if (start && !busy)
        begin
            op_reg  <= opcode;
            din_reg <= data_in;
        end
    end

    sdes_key_sched u_key
    (
        .key (key_reg),
        .k1  (k1),
        .k2  (k2)
    );

    always_comb
    begin
        if (op_reg == sdes_pkg::OP_DEC)
        begin
            first_key  = k2;
            second_key = k1;
        end
        else
        begin
            first_key  = k1;
            second_key = k2;
        end
        r1_in     = sdes_pkg::ip(din_reg);
        // swap halves between the rounds
        r2_in     = {r1_out[3:0], r1_out[7:4]};
        dout_next = sdes_pkg::ip_inv(r2_out);
    end

    sdes_round u_round1
    (
        .blk_in  (r1_in),
        .subkey  (first_key),
        .alt_s1  (alt_reg),
        .blk_out (r1_out)
    );

    sdes_round u_round2
    (
        .blk_in  (r2_in),
        .subkey  (second_key),
        .alt_s1  (alt_reg),
        .blk_out (r2_out)
    );

    // result register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            done_reg <= 1'b0;
        else
            done_reg <= vld_reg;
    end

    always_ff @(posedge clk)
    begin
        if (vld_reg)
            dout_reg <= dout_next;
    end

endmodule

// ===== sv/sdes_checker.sv =====
// Port-level checker for the S-DES byte cipher, bound to the top level.
module sdes_checker
(
    input logic                       clk,
    input logic                       rst_n,
    input logic                       start,
    input logic                       busy,
    input logic                       opcode,
    input logic [sdes_pkg::BLK_W-1:0] data_in,
    input logic                       done,
    input logic [sdes_pkg::BLK_W-1:0] data_out,
    input logic                       wr_en
);

    // every taken beat yields a result with done high
    a_beat_to_done: assert property (@(posedge clk) disable iff (!rst_n)
        (start && !busy) |-> ##2 done)
        else $error("taken beat produced no result");

    // no result without a matching beat taken earlier
    a_done_has_beat: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> $past(start && !busy, 2))
        else $error("result without a taken beat");

    // the block never holds off a beat
    a_never_busy: assert property (@(posedge clk) disable iff (!rst_n)
        !busy)
        else $error("busy raised");

    // two identical back-to-back beats under the same configuration agree
    a_same_beat_same_result: assert property (@(posedge clk) disable iff (!rst_n)
        (start && !busy && $past(start && !busy) && !wr_en
         && opcode == $past(opcode) && data_in == $past(data_in))
        |-> ##2 (done && $stable(data_out)))
        else $error("identical beats gave different results");

endmodule

bind sdes_byte_cipher sdes_checker u_sdes_checker
(
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (start),
    .busy     (busy),
    .opcode   (opcode),
    .data_in  (data_in),
    .done     (done),
    .data_out (data_out),
    .wr_en    (wr_en)
);
